[hw/rtl/assert_macros.svh]
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/cpf_pkg.sv]
package cpf_pkg;

  localparam int COORD_W   = 16;
  localparam int LEN_W     = 15;
  localparam int FRAC_BITS = 12;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X     = 3'd0,
    CFG_START_Y     = 3'd1,
    CFG_START_Z     = 3'd2,
    CFG_DIR_X       = 3'd3,
    CFG_DIR_Y       = 3'd4,
    CFG_DIR_Z       = 3'd5,
    CFG_AXIS_LENGTH = 3'd6,
    CFG_CYL_RADIUS  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    coord_t             start_x;
    coord_t             start_y;
    coord_t             start_z;
    coord_t             dir_x;
    coord_t             dir_y;
    coord_t             dir_z;
    logic [LEN_W-1:0]   axis_length;
    logic [LEN_W-1:0]   cyl_radius;
  } cfg_t;

  // unit vector along x
  localparam coord_t DIR_X_RST = 16'sd4096;

endpackage

[hw/rtl/cpf_in_if.sv]
interface cpf_in_if import cpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

[hw/rtl/cpf_out_if.sv]
interface cpf_out_if import cpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

[hw/rtl/cpf_cfg_regs.sv]
module cpf_cfg_regs import cpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_START_X:     cfg_nxt.start_x     = coord_t'(cfg_wdata);
        CFG_START_Y:     cfg_nxt.start_y     = coord_t'(cfg_wdata);
        CFG_START_Z:     cfg_nxt.start_z     = coord_t'(cfg_wdata);
        CFG_DIR_X:       cfg_nxt.dir_x       = coord_t'(cfg_wdata);
        CFG_DIR_Y:       cfg_nxt.dir_y       = coord_t'(cfg_wdata);
        CFG_DIR_Z:       cfg_nxt.dir_z       = coord_t'(cfg_wdata);
        CFG_AXIS_LENGTH: cfg_nxt.axis_length = cfg_wdata[LEN_W-1:0];
        CFG_CYL_RADIUS:  cfg_nxt.cyl_radius  = cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_x: '0, start_y: '0, start_z: '0, dir_x: DIR_X_RST,
                 dir_y: '0, dir_z: '0, axis_length: '0, cyl_radius: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/cpf_pipe.sv]
`include "assert_macros.svh"

module cpf_pipe import cpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  cpf_in_if.sink    in_pt,
  cpf_out_if.source out_pt
);

  // stage valids: [0]=diff, [1]=products, [2]=sums, [3]=t^2, [4]=radicand
  logic [4:0] vld_r;
  logic [4:0] vld_nxt;
  logic [5:0] ld;       // ld[5] loads the output register
  logic       out_vld_r;
  logic       out_vld_nxt;

  // point payload travels with each stage
  coord_t px_r [5];
  coord_t py_r [5];
  coord_t pz_r [5];
  coord_t ox_r, oy_r, oz_r;

  // stage 1
  logic signed [COORD_W:0] vx_r, vy_r, vz_r;
  // stage 2
  logic signed [2*COORD_W:0] mx_r, my_r, mz_r;
  logic [2*COORD_W-1:0]      sx_r, sy_r, sz_r;
  // stage 3
  logic signed [2*COORD_W+2:0] t_r;
  logic [2*COORD_W+1:0]        vv3_r;
  // stage 4
  logic [54-1:0]          tt_r;
  logic [2*COORD_W+1:0]   vv4_r;
  logic [2*LEN_W-1:0]     rr4_r;
  logic                   tok4_r;
  // stage 5
  logic signed [58:0]     rad_r;
  logic [2*LEN_W-1:0]     rr5_r;
  logic                   tok5_r;

  logic signed [2*COORD_W+1:0] sqx, sqy, sqz;
  logic                        keep;

  // a stage loads when empty or when its contents move on
  always_comb begin
    ld[5] = !out_vld_r || out_pt.ready;
    for (int k = 4; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end
  assign in_pt.ready = ld[0];

  always_comb begin
    vld_nxt = vld_r;
    if (ld[0]) vld_nxt[0] = in_pt.valid;
    for (int k = 1; k < 5; k++) begin
      if (ld[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  assign keep = tok5_r && !rad_r[58]
             && (rad_r[57:0] <= {4'b0, rr5_r, {(2*FRAC_BITS){1'b0}}});
  assign out_vld_nxt = ld[5] ? (vld_r[4] && keep) : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign sqx = vx_r * vx_r;
  assign sqy = vy_r * vy_r;
  assign sqz = vz_r * vz_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      px_r[0] <= in_pt.in_x;
      py_r[0] <= in_pt.in_y;
      pz_r[0] <= in_pt.in_z;
      vx_r    <= {in_pt.in_x[COORD_W-1], in_pt.in_x} - {cfg.start_x[COORD_W-1], cfg.start_x};
      vy_r    <= {in_pt.in_y[COORD_W-1], in_pt.in_y} - {cfg.start_y[COORD_W-1], cfg.start_y};
      vz_r    <= {in_pt.in_z[COORD_W-1], in_pt.in_z} - {cfg.start_z[COORD_W-1], cfg.start_z};
    end
    if (ld[1]) begin
      px_r[1] <= px_r[0];
      py_r[1] <= py_r[0];
      pz_r[1] <= pz_r[0];
      mx_r    <= cfg.dir_x * vx_r;
      my_r    <= cfg.dir_y * vy_r;
      mz_r    <= cfg.dir_z * vz_r;
      // |v| < 2^16, so each square fits 32 bits
      sx_r    <= sqx[2*COORD_W-1:0];
      sy_r    <= sqy[2*COORD_W-1:0];
      sz_r    <= sqz[2*COORD_W-1:0];
    end
    if (ld[2]) begin
      px_r[2] <= px_r[1];
      py_r[2] <= py_r[1];
      pz_r[2] <= pz_r[1];
      t_r     <= {{2{mx_r[2*COORD_W]}}, mx_r} + {{2{my_r[2*COORD_W]}}, my_r}
               + {{2{mz_r[2*COORD_W]}}, mz_r};
      vv3_r   <= {2'b0, sx_r} + {2'b0, sy_r} + {2'b0, sz_r};
    end
    if (ld[3]) begin
      px_r[3] <= px_r[2];
      py_r[3] <= py_r[2];
      pz_r[3] <= pz_r[2];
      // t in range implies t < 2^27; square is only used then
      tok4_r  <= !t_r[2*COORD_W+2]
              && (t_r[2*COORD_W+1:0] <= {7'b0, cfg.axis_length, {FRAC_BITS{1'b0}}});
      tt_r    <= {27'b0, t_r[26:0]} * {27'b0, t_r[26:0]};
      vv4_r   <= vv3_r;
      rr4_r   <= cfg.cyl_radius * cfg.cyl_radius;
    end
    if (ld[4]) begin
      px_r[4] <= px_r[3];
      py_r[4] <= py_r[3];
      pz_r[4] <= pz_r[3];
      rad_r   <= $signed({1'b0, vv4_r, {(2*FRAC_BITS){1'b0}}}) - $signed({5'b0, tt_r});
      rr5_r   <= rr4_r;
      tok5_r  <= tok4_r;
    end
    if (ld[5]) begin
      ox_r <= px_r[4];
      oy_r <= py_r[4];
      oz_r <= pz_r[4];
    end
  end

  assign out_pt.valid = out_vld_r;
  assign out_pt.out_x = ox_r;
  assign out_pt.out_y = oy_r;
  assign out_pt.out_z = oz_r;

  `ASSERT_IMPL(a_ready_when_out_empty, !out_vld_r, in_pt.ready)
  `ASSERT_NEXT(a_stage_holds, vld_r[4] && !ld[5], vld_r[4])
  `ASSERT_NEXT(a_kept_point_shown, vld_r[4] && ld[5] && keep, out_vld_r)
  `ASSERT_NEXT(a_drop_no_beat, ld[5] && !(vld_r[4] && keep), !out_vld_r)

endmodule

[hw/rtl/cylinder_point_filter_top.sv]
// Channel  Dir  Payload                         Handshake
// in_pt    in   in_x, in_y, in_z (s16 Q4.12)    valid/ready
// out_pt   out  out_x, out_y, out_z (s16 Q4.12) valid/ready
// cfg      in   cfg_idx[2:0], cfg_wdata[15:0]   cfg_we, no back-pressure
//
// One point per cycle sustained while out_pt.ready stays high; a kept point passes the
// subtract, multiply, sum, t^2 multiply, radicand and compare stages before it reaches out_pt.
// rst_n is synchronous: pipeline empties, config registers return to their reset values.
// Stalls ripple back stage by stage, so bubbles close up and in_pt.ready stays high
// while any stage ahead is empty; dropped points leave no output beat.
module cylinder_point_filter_top import cpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_wdata,
  cpf_in_if.sink               in_pt,
  cpf_out_if.source            out_pt
);

  cfg_t cfg;

  cpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cpf_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_pt  (in_pt),
    .out_pt (out_pt)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpf_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct {
    coord_t           start_x;
    coord_t           start_y;
    coord_t           start_z;
    coord_t           dir_x;
    coord_t           dir_y;
    coord_t           dir_z;
    logic [LEN_W-1:0] axis_len;
    logic [LEN_W-1:0] radius;
  } geom_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0]   cfg_wdata;

  cpf_in_if  in_pt ();
  cpf_out_if out_pt ();

  cylinder_point_filter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pt     (in_pt),
    .out_pt    (out_pt)
  );

  geom_t  geom;
  point_t kept_q[$];
  point_t want_pt;
  int     err_count = 0;
  int     points_sent;
  int     points_kept = 0;
  int     geom_count;
  int     send_idle_pct;
  int     stall_pct;
  int     span;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // cylinder predictor
  // ---------------------------------------------------------------------------
  function automatic void geom_reset();
    geom.start_x  = '0;
    geom.start_y  = '0;
    geom.start_z  = '0;
    geom.dir_x    = DIR_X_RST;
    geom.dir_y    = '0;
    geom.dir_z    = '0;
    geom.axis_len = '0;
    geom.radius   = '0;
  endfunction

  // projection in Q.24, distances squared compared in Q.48, all exact
  function automatic bit point_is_kept(point_t p);
    longint vx;
    longint vy;
    longint vz;
    longint proj;
    longint dist_sq48;
    longint proj_sq;
    longint rad_sq48;
    vx = longint'(p.x) - longint'(geom.start_x);
    vy = longint'(p.y) - longint'(geom.start_y);
    vz = longint'(p.z) - longint'(geom.start_z);
    proj = longint'(geom.dir_x) * vx + longint'(geom.dir_y) * vy + longint'(geom.dir_z) * vz;
    if (proj < 0) return 1'b0;
    if (proj > (longint'(geom.axis_len) <<< FRAC_BITS)) return 1'b0;
    proj_sq   = proj * proj;
    dist_sq48 = (vx * vx + vy * vy + vz * vz) <<< (2 * FRAC_BITS);
    if (dist_sq48 < proj_sq) return 1'b0;  // negative radicand
    rad_sq48  = (longint'(geom.radius) * longint'(geom.radius)) <<< (2 * FRAC_BITS);
    return (dist_sq48 - proj_sq) <= rad_sq48;
  endfunction

  function automatic point_t mk_pt(int x, int y, int z);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers and checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 100)
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    unique case (idx)
      CFG_START_X:     geom.start_x  = coord_t'(val);
      CFG_START_Y:     geom.start_y  = coord_t'(val);
      CFG_START_Z:     geom.start_z  = coord_t'(val);
      CFG_DIR_X:       geom.dir_x    = coord_t'(val);
      CFG_DIR_Y:       geom.dir_y    = coord_t'(val);
      CFG_DIR_Z:       geom.dir_z    = coord_t'(val);
      CFG_AXIS_LENGTH: geom.axis_len = val[LEN_W-1:0];
      CFG_CYL_RADIUS:  geom.radius   = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_cylinder(coord_t sx, coord_t sy, coord_t sz,
                              coord_t dx, coord_t dy, coord_t dz,
                              logic [COORD_W-1:0] len, logic [COORD_W-1:0] rad);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_AXIS_LENGTH, len);
    write_reg(CFG_CYL_RADIUS, rad);
    geom_count++;
  endtask

  // dropped points leave no beat, so give the pipeline time to empty
  task automatic wait_drained();
    in_pt.valid = 1'b0;
    while (kept_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pt.valid = 1'b0;
      @(negedge clk);
    end
    in_pt.valid = 1'b1;
    in_pt.in_x  = p.x;
    in_pt.in_y  = p.y;
    in_pt.in_z  = p.z;
    do @(posedge clk); while (!in_pt.ready);
    points_sent++;
    if (point_is_kept(p)) kept_q.push_back(p);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_pt.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pt.valid && out_pt.ready) begin
      if (kept_q.size() == 0) begin
        report_mismatch("output beat with no kept point pending, x", int'(out_pt.out_x), 0);
      end else begin
        want_pt = kept_q.pop_front();
        points_kept++;
        if (out_pt.out_x !== want_pt.x) report_mismatch("out_x", int'(out_pt.out_x), int'(want_pt.x));
        if (out_pt.out_y !== want_pt.y) report_mismatch("out_y", int'(out_pt.out_y), int'(want_pt.y));
        if (out_pt.out_z !== want_pt.z) report_mismatch("out_z", int'(out_pt.out_z), int'(want_pt.z));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset geometry: unit x axis, zero length and radius, only the origin passes
  task automatic test_reset_defaults();
    send_point(mk_pt(0, 0, 0));
    send_point(mk_pt(1, 0, 0));
    send_point(mk_pt(-1, 0, 0));
    send_point(mk_pt(0, 1, 0));
  endtask

  // axis along +y, both ends and the radius hit exactly and missed by one LSB
  task automatic test_axis_bounds();
    wait_drained();
    set_cylinder(4096, -4096, 0, 0, 4096, 0, 8192, 2048);
    send_point(mk_pt(4096, -4096, 0));
    send_point(mk_pt(4096, 4096, 0));
    send_point(mk_pt(4096, 4097, 0));
    send_point(mk_pt(4096, -4097, 0));
    send_point(mk_pt(6144, 0, 0));
    send_point(mk_pt(4096, 0, 2049));
  endtask

  // direction longer than one, so t^2 outgrows |v|^2 along the axis
  task automatic test_negative_radicand();
    wait_drained();
    set_cylinder(0, 0, 0, 8192, 0, 0, 4096, 32767);
    send_point(mk_pt(1024, 0, 0));
    send_point(mk_pt(0, 0, 0));
    send_point(mk_pt(1024, 4096, 0));
  endtask

  // zero direction: t is always 0, only the distance from start matters
  task automatic test_zero_direction();
    wait_drained();
    set_cylinder(-8192, 8192, 100, 0, 0, 0, 0, 4096);
    send_point(mk_pt(-8192, 8192, 100));
    send_point(mk_pt(-4096, 8192, 100));
    send_point(mk_pt(-4095, 8192, 100));
    send_point(mk_pt(-8192, 8192 + 2896, 100 + 2896));
  endtask

  task automatic test_extremes();
    wait_drained();
    set_cylinder(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767);
    send_point(mk_pt(32767, 32767, 32767));
    send_point(mk_pt(-32768, -32768, -32768));
    send_point(mk_pt(-32767, -32768, -32768));
    wait_drained();
    set_cylinder(32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
    send_point(mk_pt(32767, 32767, 32767));
    send_point(mk_pt(-32768, -32768, -32768));
    send_point(mk_pt(32767, 32767, -32768));
  endtask

  task automatic pick_geometry(int kind);
    int     dir[3];
    int     st[3];
    int     axis;
    logic [COORD_W-1:0] len;
    logic [COORD_W-1:0] rad;
    dir = '{0, 0, 0};
    for (int i = 0; i < 3; i++) st[i] = int'($urandom_range(0, 16383)) - 8192;
    unique case (kind)
      0: begin
        axis = $urandom_range(0, 2);
        dir[axis] = $urandom_range(0, 1) ? 4096 : -4096;
        len  = 16'($urandom_range(0, 8192));
        rad  = 16'($urandom_range(0, 4096));
        span = ((len > rad) ? int'(len) : int'(rad)) + 16;
      end
      1: begin
        for (int i = 0; i < 3; i++) dir[i] = int'($urandom_range(0, 8192)) - 4096;
        len  = 16'($urandom_range(0, 8192));
        rad  = 16'($urandom_range(0, 4096));
        span = ((len > rad) ? int'(len) : int'(rad)) + 16;
      end
      2: begin
        len  = 16'($urandom_range(0, 32767));
        rad  = 16'($urandom_range(0, 8192));
        span = int'(rad) + 64;
      end
      default: begin
        // full range; bit 15 of the length and radius writes must be ignored
        for (int i = 0; i < 3; i++) begin
          dir[i] = int'($urandom_range(0, 65535)) - 32768;
          st[i]  = int'($urandom_range(0, 65535)) - 32768;
        end
        len  = 16'($urandom);
        rad  = 16'($urandom);
        span = 32767;
      end
    endcase
    set_cylinder(coord_t'(st[0]), coord_t'(st[1]), coord_t'(st[2]),
                 coord_t'(dir[0]), coord_t'(dir[1]), coord_t'(dir[2]), len, rad);
  endtask

  // mostly points scattered around the cylinder, the rest anywhere
  task automatic test_random_points(int n_segments, int per_segment);
    int     phase;
    point_t p;
    for (int seg = 0; seg < n_segments; seg++) begin
      wait_drained();
      pick_geometry(seg % 4);
      phase = (seg + seg / 4) % 4;
      unique case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (int i = 0; i < per_segment; i++) begin
        if ($urandom_range(99) < 70) begin
          p.x = coord_t'(int'(geom.start_x) + int'($urandom_range(0, 2 * span)) - span);
          p.y = coord_t'(int'(geom.start_y) + int'($urandom_range(0, 2 * span)) - span);
          p.z = coord_t'(int'(geom.start_z) + int'($urandom_range(0, 2 * span)) - span);
        end else begin
          p.x = coord_t'($urandom);
          p.y = coord_t'($urandom);
          p.z = coord_t'($urandom);
        end
        send_point(p);
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_START_X;
    cfg_wdata     = '0;
    in_pt.valid   = 1'b0;
    in_pt.in_x    = '0;
    in_pt.in_y    = '0;
    in_pt.in_z    = '0;
    points_sent   = 0;
    geom_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    span          = 0;
    waited        = 0;
    geom_reset();

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_axis_bounds();
    test_negative_radicand();
    test_zero_direction();
    test_extremes();
    test_random_points(8, 156);

    in_pt.valid = 1'b0;
    while (kept_q.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (12) @(negedge clk);
    if (kept_q.size() != 0)
      report_mismatch("kept points never delivered", 0, kept_q.size());

    $display("%0d points streamed, %0d kept points checked, %0d cylinder geometries",
             points_sent, points_kept, geom_count);
    $display("handshake mixes: free flowing, sparse input, output back-pressure, both");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
